FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL; no dependencies.
// Checks compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: rtl/dq_pkg.sv
// Types, constants and ring-index helpers for the double-ended queue.
// No dependencies; used by double_ended_queue_core.
package dq_pkg;

   localparam int DEPTH  = 32;
   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int DATA_W = 32;
   localparam int OCC_W  = 6;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_REAR  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_REAR   = 3'd3;
   localparam logic [2:0] KIND_LIST       = 3'd4;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic [1:0]               status;
      logic [OCC_W-1:0]         occupancy;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_POP,
      S_LIST
   } state_type;

   // (a + b) mod DEPTH, both operands below DEPTH
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
      logic [IDX_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   // (a - 1) mod DEPTH
   function automatic logic [IDX_W-1:0] ring_dec(input logic [IDX_W-1:0] a);
      logic [IDX_W-1:0] r;
      if (a == '0) begin
         r = IDX_W'(DEPTH - 1);
      end else begin
         r = a - 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/dq_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // hold read data until the next read
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

FILE: rtl/double_ended_queue_core.sv
// Channel  Direction  Payload   Accepted when
// req      in         req_type  req_valid && req_ready
// rsp      out        rsp_type  rsp_valid && rsp_ready
//
// Pushes, overflows, underflows and empty lists load the result in the cycle they are taken.
// Pops read the entry from the RAM (registered read), then load it.
// A list reads one entry per cycle unless the output stalls; N held entries give N results.
// One item is in flight at a time; a new item is taken only when the output register is
// empty or its result leaves in the same cycle, so a waiting result holds off the input.
// Reset (synchronous) empties the queue; entries need no clearing.
// Depends on dq_pkg, dq_ram and assert_macros.svh.
`include "assert_macros.svh"

module double_ended_queue_core
   import dq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] off_ff, off_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic              wr_en, rd_en;
   logic [IDX_W-1:0]  wr_addr, rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic              out_free, full, empty, take;
   logic              load;
   logic [DATA_W-1:0] load_data;
   logic [1:0]        load_status;
   logic              load_last;

   dq_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign take     = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      off_in       = off_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = head_ff;
      rd_en        = 1'b0;
      rd_addr      = head_ff;
      load         = 1'b0;
      load_data    = '0;
      load_status  = ST_OK;
      load_last    = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = out_free;
            if (take) begin
               unique case (req_data.kind)
                  KIND_PUSH_FRONT: begin
                     load = 1'b1;
                     if (full) begin
                        load_status = ST_OVERFLOW;
                     end else begin
                        head_in  = ring_dec(head_ff);
                        wr_en    = 1'b1;
                        wr_addr  = head_in;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_PUSH_REAR: begin
                     load = 1'b1;
                     if (full) begin
                        load_status = ST_OVERFLOW;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = ring_add(head_ff, IDX_W'(count_ff));
                        count_in = count_ff + 1'b1;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (empty) begin
                        load        = 1'b1;
                        load_status = ST_UNDERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        head_in  = ring_add(head_ff, IDX_W'(1));
                        count_in = count_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  KIND_POP_REAR: begin
                     if (empty) begin
                        load        = 1'b1;
                        load_status = ST_UNDERFLOW;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = ring_add(head_ff, IDX_W'(count_ff - 1'b1));
                        count_in = count_ff - 1'b1;
                        state_in = S_POP;
                     end
                  end
                  KIND_LIST: begin
                     if (empty) begin
                        load        = 1'b1;
                        load_status = ST_EMPTY;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = head_ff;
                        off_in   = '0;
                        state_in = S_LIST;
                     end
                  end
                  default: begin
                     // unused kind: drop the item
                  end
               endcase
            end
         end
         S_POP: begin
            if (out_free) begin
               load      = 1'b1;
               load_data = rd_data;
               state_in  = S_IDLE;
            end
         end
         S_LIST: begin
            if (out_free) begin
               load      = 1'b1;
               load_data = rd_data;
               load_last = (CNT_W'(off_ff) + CNT_W'(1) == count_ff);
               if (load_last) begin
                  state_in = S_IDLE;
               end else begin
                  // advance to the next entry
                  off_in  = off_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = ring_add(head_ff, off_in);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.data      = load_data;
         rsp_in.status    = load_status;
         rsp_in.occupancy = OCC_W'(count_in);
         rsp_in.last      = load_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count above depth")
   `ASSERT_IMPLIES(a_list_nonempty, clock, reset, state_ff == S_LIST, count_ff != '0, "list while empty")
   `ASSERT_IMPLIES(a_err_data_zero, clock, reset, rsp_valid_ff && rsp_ff.status != ST_OK, rsp_ff.data == '0, "error result with data")
   `ASSERT_NEXT(a_underflow, clock, reset, take && empty && (req_data.kind == KIND_POP_FRONT || req_data.kind == KIND_POP_REAR), rsp_valid_ff && rsp_ff.status == ST_UNDERFLOW && rsp_ff.last, "missing underflow result")

endmodule
